// ===== hw/rtl/tla_pkg.sv =====
// Shared types, widths and a helper function of the tour length accumulator.
package tla_pkg;

  // Field widths of the stream items.
  localparam int unsigned COORD_W = 24;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned TOTAL_W = 48;

  // Packed stream data widths, rounded up to whole bytes.
  localparam int unsigned S_TDATA_W = 64;
  localparam int unsigned M_TDATA_W = 48;

  // Datapath widths: absolute coordinate difference, its square, the sum of two
  // squares, and the root.
  localparam int unsigned ABS_W  = COORD_W;
  localparam int unsigned SQ_W   = 2 * ABS_W;
  localparam int unsigned SUM_W  = SQ_W + 1;
  localparam int unsigned ROOT_W = 25;

  // The square root retires one result bit per cycle.
  localparam int unsigned SQRT_STEPS = ROOT_W;
  localparam int unsigned RAD_W      = 2 * SQRT_STEPS;
  localparam int unsigned REM_W      = ROOT_W + 2;
  localparam int unsigned STEP_CNT_W = $clog2(SQRT_STEPS + 1);

  // Width that compares a city index against any supported table depth.
  localparam int unsigned IDX_CMP_W = 17;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Operation codes carried in tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_VISIT = 1'b1;

  // Number of visits seen in the current tour.
  localparam logic [1:0] VISITS_NONE = 2'd0;
  localparam logic [1:0] VISITS_ONE  = 2'd1;
  localparam logic [1:0] VISITS_MANY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_START,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } tla_state_e;

  // Absolute difference of two signed coordinates.
  function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] n;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    n = -d;
    return d[COORD_W] ? n[ABS_W-1:0] : d[ABS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/tla_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tla_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tla_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module tla_sqrt import tla_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W-1:0]      rad_q, rad_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  done_q, done_d;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] rem_sub;

  // One restoring step: bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh  = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    rem_sub = rem_sh - trial;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = STEP_CNT_W'(SQRT_STEPS);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sub[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == STEP_CNT_W'(1));
    end
  end

  // Step counter and done flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/tour_length_accumulator_unit.sv =====
// Top level of the tour length accumulator: city table, control and leg datapath.
//
//  Port group  Dir  tdata                                   tuser         tlast
//  s_axis      in   city_index, coord_x, coord_y            operation     last
//  m_axis      out  tour_length                             saturated     -
//
// A load beat is written on acceptance and another beat may follow at once.
// A visit beat passes through a table read, a squaring step, a step to start the
// root, the bit-serial square root and an accumulate step, and no beat is taken
// until it is done. The first visit of a tour only reads the table. The last visit
// runs a second leg back to the first city. The result waits in an output register;
// a stall on m_axis holds only the final emit step, and reset clears all tour state.
// The table is not cleared.
module tour_length_accumulator_unit import tla_pkg::*; #(
  parameter int unsigned MAX_CITIES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Fields from bit 0 up: city_index[9:0], coord_x[33:10], coord_y[57:34], zeros.
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // Field: operation.
  input  logic                 s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // Field: tour_length[47:0].
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // Field: saturated.
  output logic                 m_axis_tuser_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_CITIES);

  tla_state_e state_q, state_d;

  // Input beat fields.
  logic [INDEX_W-1:0]   in_index;
  logic [COORD_W-1:0]   in_x;
  logic [COORD_W-1:0]   in_y;
  logic [IDX_CMP_W-1:0] idx_ext;
  logic                 idx_ok;
  logic                 in_fire;

  // Table port.
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_addr;
  logic [2*COORD_W-1:0]   ram_rdata;

  // Tour state.
  logic [COORD_W-1:0] cur_x_q, cur_y_q;
  logic [COORD_W-1:0] first_x_q, first_y_q;
  logic [COORD_W-1:0] prev_x_q, prev_y_q;
  logic [TOTAL_W-1:0] total_q;
  logic [1:0]         visits_q;
  logic               clip_q;
  logic               last_q;
  logic               idx_ok_q;
  logic               closing_q;

  // Leg datapath.
  logic [ABS_W-1:0]  adx_q, ady_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q;
  logic [SUM_W-1:0]  sq_sum;
  logic              sqrt_start;
  logic              sqrt_done;
  logic [ROOT_W-1:0] leg;
  logic [TOTAL_W:0]  total_sum;
  logic [COORD_W-1:0] rd_x, rd_y;

  // Output register.
  logic [TOTAL_W-1:0] out_len_q;
  logic               out_sat_q;
  logic               out_valid_q;
  logic               emit_go;

  assign in_index = s_axis_tdata_i[INDEX_W-1:0];
  assign in_x     = s_axis_tdata_i[INDEX_W +: COORD_W];
  assign in_y     = s_axis_tdata_i[INDEX_W+COORD_W +: COORD_W];
  assign idx_ext  = {{(IDX_CMP_W-INDEX_W){1'b0}}, in_index};
  assign idx_ok   = idx_ext < IDX_CMP_W'(MAX_CITIES);
  assign ram_addr = idx_ext[ADDR_W-1:0];
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  // Read data of an out-of-range visit counts as the origin.
  assign rd_x = idx_ok_q ? ram_rdata[COORD_W-1:0] : '0;
  assign rd_y = idx_ok_q ? ram_rdata[2*COORD_W-1:COORD_W] : '0;

  assign sq_sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign total_sum = {1'b0, total_q} + (TOTAL_W+1)'(leg);

  // Table of city coordinates, x in the low half. Only one beat is in flight,
  // so a load and a later visit of the same slot never overlap.
  tla_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_CITIES)
  ) u_city_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i ({in_y, in_x}),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  tla_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({{(RAD_W-SUM_W){1'b0}}, sq_sum}),
    .done_o     (sqrt_done),
    .root_o     (leg)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser_i == OP_VISIT) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (visits_q != VISITS_NONE) begin
          state_d = ST_SQUARE;
        end else if (last_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SQUARE: state_d = ST_START;
      ST_START:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (last_q && !closing_q) begin
          state_d = ST_SQUARE;
        end else if (last_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    sqrt_start      = 1'b0;
    emit_go         = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready_o = 1'b1;
      ST_START: sqrt_start = 1'b1;
      ST_EMIT:  emit_go = !out_valid_q || m_axis_tready_i;
      default: begin
      end
    endcase
    ram_we = in_fire && s_axis_tuser_i == OP_LOAD && idx_ok;
    ram_re = in_fire && s_axis_tuser_i == OP_VISIT;
  end

  // Control registers and tour state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      total_q     <= '0;
      visits_q    <= VISITS_NONE;
      clip_q      <= 1'b0;
      last_q      <= 1'b0;
      idx_ok_q    <= 1'b0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Capture the visit beat.
      if (ram_re) begin
        last_q    <= s_axis_tlast_i;
        idx_ok_q  <= idx_ok;
        closing_q <= 1'b0;
      end

      // The first visit of a tour only records its city.
      if (state_q == ST_READ && visits_q == VISITS_NONE) begin
        first_x_q <= rd_x;
        first_y_q <= rd_y;
        prev_x_q  <= rd_x;
        prev_y_q  <= rd_y;
        visits_q  <= VISITS_ONE;
      end

      // Add a leg with saturation; the closing leg follows on a last visit.
      if (state_q == ST_ACC) begin
        if (total_sum[TOTAL_W]) begin
          total_q <= TOTAL_MAX;
          clip_q  <= 1'b1;
        end else begin
          total_q <= total_sum[TOTAL_W-1:0];
        end
        prev_x_q  <= cur_x_q;
        prev_y_q  <= cur_y_q;
        visits_q  <= VISITS_MANY;
        closing_q <= last_q;
      end

      // Hand the result over and clear the tour.
      if (emit_go) begin
        first_x_q <= '0;
        first_y_q <= '0;
        prev_x_q  <= '0;
        prev_y_q  <= '0;
        total_q   <= '0;
        visits_q  <= VISITS_NONE;
        clip_q    <= 1'b0;
      end

      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      cur_x_q <= rd_x;
      cur_y_q <= rd_y;
      adx_q   <= abs_diff(rd_x, prev_x_q);
      ady_q   <= abs_diff(rd_y, prev_y_q);
    end
    if (state_q == ST_ACC) begin
      adx_q <= abs_diff(first_x_q, cur_x_q);
      ady_q <= abs_diff(first_y_q, cur_y_q);
    end
    if (state_q == ST_SQUARE) begin
      sqx_q <= adx_q * adx_q;
      sqy_q <= ady_q * ady_q;
    end
    if (emit_go) begin
      out_len_q <= total_q;
      out_sat_q <= clip_q;
    end
  end

  assign m_axis_tdata_o  = out_len_q;
  assign m_axis_tuser_o  = out_sat_q;
  assign m_axis_tvalid_o = out_valid_q;

  // A clipped total stays pinned at its maximum until the tour is cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_q |-> total_q == TOTAL_MAX)
    else $error("clip flag set with total below maximum");

  // The root unit reports completion only while the control waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == ST_ROOT)
    else $error("square root finished outside the root wait");

  // Emitting a result leaves a clear tour behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go |=> total_q == '0 && visits_q == VISITS_NONE && !clip_q && m_axis_tvalid_o)
    else $error("tour state not cleared after a result");

  // A total only grows while no result is emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |=> total_q >= $past(total_q))
    else $error("running total decreased on a leg");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the tour length accumulator: driver, monitor and tour predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tla_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int ITEM_TARGET  = 1700;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic               op;
    logic [INDEX_W-1:0] idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } city_beat_t;

  typedef struct {
    logic [TOTAL_W-1:0] length;
    logic               sat;
  } tour_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 s_tlast  = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;

  tour_length_accumulator_unit #(
    .MAX_CITIES(TABLE_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready)
  );

  // Free-running 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stimulus bookkeeping.
  city_beat_t   beat_q[$];
  city_beat_t   next_beat;
  int           loaded_slots[$];
  bit           slot_loaded[TABLE_DEPTH];
  int           total_items = ITEM_TARGET;

  // Predicted tour state and the table mirror.
  logic signed [COORD_W-1:0] x_tab[TABLE_DEPTH];
  logic signed [COORD_W-1:0] y_tab[TABLE_DEPTH];
  logic signed [COORD_W-1:0] first_x = '0, first_y = '0, prev_x = '0, prev_y = '0;
  logic [TOTAL_W-1:0]        tour_sum = '0;
  logic                      tour_clip = 1'b0;
  logic [1:0]                visit_count = VISITS_NONE;
  tour_result_t              tour_q[$];
  tour_result_t              want, got;
  city_beat_t                seen_beat;

  // Run statistics.
  int in_beats = 0;
  int load_beats = 0;
  int visit_beats = 0;
  int tours_closed = 0;
  int single_tours = 0;
  int errors = 0;
  logic [TOTAL_W-1:0] longest_tour = '0;

  // Flow control state.
  int hold_left = 0;
  bit hold_used = 1'b0;
  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cycles = 0;

  // Floor square root, one result bit per iteration from the top.
  function automatic logic [ROOT_W-1:0] root_floor(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r[ROOT_W-1:0];
  endfunction

  // Euclidean distance between two cities, rounded down.
  function automatic logic [ROOT_W-1:0] hop_distance(input logic signed [COORD_W-1:0] ax,
                                                     input logic signed [COORD_W-1:0] ay,
                                                     input logic signed [COORD_W-1:0] bx,
                                                     input logic signed [COORD_W-1:0] by);
    longint dx;
    longint dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return root_floor(64'(dx * dx + dy * dy));
  endfunction

  // Add one leg to the running total, clipping at the top of the range.
  function automatic void accumulate_hop(input logic [ROOT_W-1:0] hop);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, tour_sum} + (TOTAL_W + 1)'(hop);
    if (sum > {1'b0, TOTAL_MAX}) begin
      tour_sum  = TOTAL_MAX;
      tour_clip = 1'b1;
    end else begin
      tour_sum = sum[TOTAL_W-1:0];
    end
  endfunction

  // Apply one accepted beat to the predicted state; a last visit queues a result.
  function automatic void advance_tour(input city_beat_t b);
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    tour_result_t res;
    if (b.op == OP_LOAD) begin
      if (b.idx < TABLE_DEPTH) begin
        x_tab[b.idx] = b.x;
        y_tab[b.idx] = b.y;
      end
      load_beats++;
      return;
    end
    visit_beats++;
    cx = (b.idx < TABLE_DEPTH) ? x_tab[b.idx] : '0;
    cy = (b.idx < TABLE_DEPTH) ? y_tab[b.idx] : '0;
    if (visit_count == VISITS_NONE) begin
      first_x     = cx;
      first_y     = cy;
      visit_count = VISITS_ONE;
    end else begin
      accumulate_hop(hop_distance(cx, cy, prev_x, prev_y));
      visit_count = VISITS_MANY;
    end
    prev_x = cx;
    prev_y = cy;
    if (!b.last) return;
    if (visit_count == VISITS_MANY) begin
      accumulate_hop(hop_distance(first_x, first_y, cx, cy));
      res.length = tour_sum;
      res.sat    = tour_clip;
    end else begin
      res.length = '0;
      res.sat    = 1'b0;
      single_tours++;
    end
    tour_q.push_back(res);
    first_x     = '0;
    first_y     = '0;
    prev_x      = '0;
    prev_y      = '0;
    tour_sum    = '0;
    tour_clip   = 1'b0;
    visit_count = VISITS_NONE;
  endfunction

  // Coordinate mix: full random, small values around zero, and the corners.
  function automatic logic [COORD_W-1:0] pick_coord();
    logic [31:0]        r;
    logic [COORD_W-1:0] corner[4];
    corner = '{24'h800000, 24'h7fffff, 24'h000000, 24'hffffff};
    r = $urandom;
    case ($urandom_range(3))
      0, 1: return r[COORD_W-1:0];
      2: return {{(COORD_W - 12){r[11]}}, r[11:0]};
      default: return corner[r[1:0]];
    endcase
  endfunction

  task automatic push_load(input int idx, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    city_beat_t b;
    b.op   = OP_LOAD;
    b.idx  = INDEX_W'(idx);
    b.x    = x;
    b.y    = y;
    b.last = 1'($urandom_range(1));
    beat_q.push_back(b);
    if (!slot_loaded[INDEX_W'(idx)]) begin
      slot_loaded[INDEX_W'(idx)] = 1'b1;
      loaded_slots.push_back(idx);
    end
  endtask

  task automatic push_visit(input int idx, input logic last);
    city_beat_t b;
    b.op   = OP_VISIT;
    b.idx  = INDEX_W'(idx);
    b.x    = COORD_W'($urandom);
    b.y    = COORD_W'($urandom);
    b.last = last;
    beat_q.push_back(b);
  endtask

  // Sender side: offer the next pending beat, idling at random between beats.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (beat_q.size() != 0 && (hold_left != 0 || $urandom_range(99) >= tx_idle_pct)) begin
        next_beat = beat_q.pop_front();
        s_tdata  <= S_TDATA_W'({next_beat.y, next_beat.x, next_beat.idx});
        s_tuser  <= next_beat.op;
        s_tlast  <= next_beat.last;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Idle rates per phase: sender light and receiver heavy, then swapped, then none.
  always_comb begin
    if (in_beats < total_items / 3) begin
      tx_idle_pct = 16;
      rx_idle_pct = 75;
    end else if (in_beats < 2 * total_items / 3) begin
      tx_idle_pct = 75;
      rx_idle_pct = 16;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  end

  // One long receiver hold-off early in the run, so the block backs up onto its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && in_beats >= 150) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Receiver side: random back-pressure, forced low during the hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: check the outgoing beat first, then predict from the incoming beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.length = m_tdata[TOTAL_W-1:0];
        got.sat    = m_tuser;
        if (tour_q.size() == 0) begin
          $error("unexpected result beat: tour_length %0d, saturated %0d", got.length, got.sat);
          errors++;
        end else begin
          want = tour_q.pop_front();
          if (got.length !== want.length) begin
            $error("tour_length: expected %0d, actual %0d", want.length, got.length);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $error("saturated: expected %0d, actual %0d", want.sat, got.sat);
            errors++;
          end
          tours_closed++;
          if (want.length > longest_tour) longest_tour = want.length;
        end
      end
      if (s_tvalid && s_tready) begin
        seen_beat.op   = s_tuser;
        seen_beat.idx  = s_tdata[INDEX_W-1:0];
        seen_beat.x    = s_tdata[INDEX_W +: COORD_W];
        seen_beat.y    = s_tdata[INDEX_W + COORD_W +: COORD_W];
        seen_beat.last = s_tlast;
        advance_tour(seen_beat);
        in_beats <= in_beats + 1;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles.", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int tour_len;
    // Directed part: corner coordinates, single-city tours, longest legs, loads mid-tour.
    push_load(0, 24'h800000, 24'h800000);
    push_load(1023, 24'h7fffff, 24'h7fffff);
    push_load(512, 24'h000000, 24'h000000);
    push_load(5, 24'h555555, 24'haaaaaa);
    push_load(6, 24'haaaaaa, 24'h555555);
    push_visit(0, 1'b1);
    push_visit(0, 1'b0);
    push_visit(1023, 1'b1);
    push_visit(512, 1'b0);
    push_load(7, 24'hffffff, 24'h000100);
    push_visit(512, 1'b0);
    push_visit(7, 1'b0);
    push_visit(5, 1'b0);
    push_visit(6, 1'b1);
    push_visit(1023, 1'b0);
    push_visit(0, 1'b0);
    push_visit(512, 1'b1);
    push_visit(5, 1'b1);

    // Random part: well-formed tours over loaded cities, with loads sprinkled in.
    // A clipped total needs millions of maximal legs, so saturation stays out of reach.
    while (beat_q.size() < ITEM_TARGET) begin
      if (loaded_slots.size() < 8 || $urandom_range(99) < 20) begin
        push_load($urandom_range(TABLE_DEPTH - 1), pick_coord(), pick_coord());
      end else begin
        tour_len = ($urandom_range(99) < 10) ? 1 : $urandom_range(9, 2);
        for (int k = 0; k < tour_len; k++) begin
          if ($urandom_range(99) < 12) begin
            push_load($urandom_range(TABLE_DEPTH - 1), pick_coord(), pick_coord());
          end
          push_visit(loaded_slots[$urandom_range(loaded_slots.size() - 1)], k == tour_len - 1);
        end
      end
    end
    total_items = beat_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every beat sent, every tour checked, then let the block settle.
    while (beat_q.size() != 0 || s_tvalid || tour_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d loads and %0d visits; checked %0d tours (%0d single-city).",
             load_beats, visit_beats, tours_closed, single_tours);
    $display("Longest tour %0d (8 fraction bits); one long output stall was applied.",
             longest_tour);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tla_pkg.sv
hw/rtl/tla_ram.sv
hw/rtl/tla_sqrt.sv
hw/rtl/tour_length_accumulator_unit.sv
test/tb.sv
